### rtl/core/iols_pkg.sv
// Shared types and codes for the indexed ordered list store.
// Holds the channel word types, command kinds, status codes and cell control.
// No dependencies.
package iols_pkg;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
    logic [4:0]  position;
  } in_word_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [4:0]  entry_total;
    logic [1:0]  status;
  } out_word_t;

  localparam logic [3:0] K_PUSH_FRONT = 4'd0;
  localparam logic [3:0] K_PUSH_BACK  = 4'd1;
  localparam logic [3:0] K_INSERT_AT  = 4'd2;
  localparam logic [3:0] K_SORTED_INS = 4'd3;
  localparam logic [3:0] K_POP_FRONT  = 4'd4;
  localparam logic [3:0] K_POP_BACK   = 4'd5;
  localparam logic [3:0] K_REMOVE_AT  = 4'd6;
  localparam logic [3:0] K_REPLACE    = 4'd7;
  localparam logic [3:0] K_READ_AT    = 4'd8;
  localparam logic [3:0] K_READ_FIRST = 4'd9;
  localparam logic [3:0] K_READ_LAST  = 4'd10;
  localparam logic [3:0] K_CLEAR      = 4'd11;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // Operation broadcast to every cell of the row
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;
  localparam logic [1:0] OP_SET  = 2'd3;

  typedef struct packed {
    logic       go;
    logic [1:0] op;
    logic       sorted;
    logic       rd_en;
  } cell_ctl_t;

endpackage

### rtl/core/indexed_ordered_list_store.sv
// Indexed ordered list store: bounded sequence with positional and sorted insert.
// Top level: command decode, a row of list cells and the result register.
// Depends on iols_pkg, iols_ctl and iols_cell.
//
// Takes one command word per clock and returns one result word in the cycle after
// acceptance; a new command is taken in the same cycle as the previous result
// leaves, so the sustained rate is one word per cycle whenever out_stall is low.
// The clock period is set by the two ripple chains through the CAPACITY cells:
// the insert/delete mark chain (with one DATA_WIDTH compare per cell for sorted
// insert) and the read-out OR chain. Every insert or delete shifts all cells from the
// target slot onward at once. Nothing needs clearing after reset: only slots below the
// count are ever read.
module indexed_ordered_list_store #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  iols_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output iols_pkg::out_word_t out_data
);
  import iols_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = DATA_WIDTH;

  logic            fire;
  cell_ctl_t       ctl;
  logic [CW-1:0]   k;
  logic [CW-1:0]   rd_idx;
  logic [1:0]      status;
  logic [CW-1:0]   cnt_next;
  logic [DW+31:0]  vwide;
  logic [DW-1:0]   vdat;
  logic [DW-1:0]   d    [CAPACITY];
  logic            mark [CAPACITY+1];
  logic [DW-1:0]   rd   [CAPACITY+1];
  logic [DW+31:0]  rd_wide;
  logic [CW+4:0]   cnt_wide;

  assign in_stall = out_valid & out_stall;
  assign fire     = in_valid & ~in_stall;

  // Fit the 32-bit word value to the slot width
  assign vwide = {{DW{1'b0}}, in_data.value};
  assign vdat  = vwide[DW-1:0];

  iols_ctl #(
    .CAPACITY(CAPACITY),
    .CW      (CW)
  ) u_ctl (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .in_word (in_data),
    .ctl     (ctl),
    .k       (k),
    .rd_idx  (rd_idx),
    .status  (status),
    .cnt_next(cnt_next)
  );

  assign mark[0] = 1'b0;
  assign rd[0]   = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DW-1:0] left_d;
    logic [DW-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = d[i];
    end else begin : g_mid_l
      assign left_d = d[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = d[i];
    end else begin : g_mid_r
      assign right_d = d[i+1];
    end

    iols_cell #(
      .CW (CW),
      .DW (DW),
      .IDX(i)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .k       (k),
      .rd_idx  (rd_idx),
      .vdat    (vdat),
      .left_d  (left_d),
      .right_d (right_d),
      .mark_in (mark[i]),
      .rd_in   (rd[i]),
      .d       (d[i]),
      .mark_out(mark[i+1]),
      .rd_out  (rd[i+1])
    );
  end

  assign rd_wide  = {32'd0, rd[CAPACITY]};
  assign cnt_wide = {5'd0, cnt_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the result word while stalled
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.read_value  <= rd_wide[31:0];
      out_data.entry_total <= cnt_wide[4:0];
      out_data.status      <= status;
    end
  end

endmodule

### rtl/core/iols_cell.sv
// One slot of the list row: holds a value and trades data with its neighbours.
// Carries the insert/delete mark chain and the read-out chain to the next cell.
// Depends on iols_pkg.
module iols_cell #(
  parameter int CW  = 5,
  parameter int DW  = 32,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  iols_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]     k,
  input  logic [CW-1:0]     rd_idx,
  input  logic [DW-1:0]     vdat,
  input  logic [DW-1:0]     left_d,
  input  logic [DW-1:0]     right_d,
  input  logic              mark_in,
  input  logic [DW-1:0]     rd_in,
  output logic [DW-1:0]     d,
  output logic              mark_out,
  output logic [DW-1:0]     rd_out
);
  import iols_pkg::*;

  localparam logic [CW-1:0] IDXC = CW'(IDX);

  logic at_k;
  logic hit;

  // In sorted mode the first cell holding a greater value claims the slot;
  // the target index (the count) catches the case where none does.
  assign at_k     = (IDXC == k);
  assign hit      = at_k | (ctl.sorted & (vdat < d));
  assign mark_out = mark_in | hit;
  assign rd_out   = rd_in | ((ctl.rd_en && (IDXC == rd_idx)) ? d : '0);

  always_ff @(posedge clk) begin
    if (ctl.go) begin
      case (ctl.op)
        OP_INS: begin
          if (mark_in) begin
            d <= left_d;
          end else if (hit) begin
            d <= vdat;
          end
        end
        OP_DEL: begin
          if (mark_out) begin
            d <= right_d;
          end
        end
        OP_SET: begin
          if (at_k) begin
            d <= vdat;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/core/iols_ctl.sv
// Command decode and element count for the indexed ordered list store.
// Checks range, empty and full, picks the target index and drives the cell row.
// Depends on iols_pkg.
module iols_ctl #(
  parameter int CAPACITY = 16,
  parameter int CW       = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  iols_pkg::in_word_t  in_word,
  output iols_pkg::cell_ctl_t ctl,
  output logic [CW-1:0]       k,
  output logic [CW-1:0]       rd_idx,
  output logic [1:0]          status,
  output logic [CW-1:0]       cnt_next
);
  import iols_pkg::*;

  localparam int CMPW = (CW > 5) ? CW : 5;

  logic [CW-1:0]   cnt;
  logic            full;
  logic            empty;
  logic [CMPW-1:0] posx;
  logic [CMPW-1:0] cntx;
  logic [CW-1:0]   pos_k;

  assign full  = (cnt == CW'(CAPACITY));
  assign empty = (cnt == '0);
  assign posx  = CMPW'(in_word.position);
  assign cntx  = CMPW'(cnt);
  assign pos_k = posx[CW-1:0];

  always_comb begin
    ctl      = '0;
    ctl.go   = fire;
    k        = '0;
    rd_idx   = '0;
    status   = ST_OK;
    cnt_next = cnt;
    case (in_word.kind)
      K_PUSH_FRONT, K_PUSH_BACK, K_INSERT_AT, K_SORTED_INS: begin
        if (full) begin
          status = ST_FULL;
        end else if ((in_word.kind == K_INSERT_AT) && (posx > cntx)) begin
          status = ST_RANGE;
        end else begin
          ctl.op   = OP_INS;
          cnt_next = cnt + CW'(1);
          if (in_word.kind == K_PUSH_FRONT) begin
            k = '0;
          end else if (in_word.kind == K_INSERT_AT) begin
            k = pos_k;
          end else begin
            k          = cnt;
            ctl.sorted = (in_word.kind == K_SORTED_INS);
          end
        end
      end
      K_POP_FRONT, K_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ctl.op   = OP_DEL;
          cnt_next = cnt - CW'(1);
          k        = (in_word.kind == K_POP_FRONT) ? '0 : cnt - CW'(1);
        end
      end
      K_REMOVE_AT: begin
        if (posx >= cntx) begin
          status = ST_RANGE;
        end else begin
          ctl.op   = OP_DEL;
          cnt_next = cnt - CW'(1);
          k        = pos_k;
        end
      end
      K_REPLACE: begin
        if (posx >= cntx) begin
          status = ST_RANGE;
        end else begin
          ctl.op = OP_SET;
          k      = pos_k;
        end
      end
      K_READ_AT: begin
        if (posx >= cntx) begin
          status = ST_RANGE;
        end else begin
          ctl.rd_en = 1'b1;
          rd_idx    = pos_k;
        end
      end
      K_READ_FIRST, K_READ_LAST: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ctl.rd_en = 1'b1;
          rd_idx    = (in_word.kind == K_READ_FIRST) ? '0 : cnt - CW'(1);
        end
      end
      K_CLEAR: begin
        cnt_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (fire) begin
      cnt <= cnt_next;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    fire && (in_word.kind == K_CLEAR) |=> (cnt == '0))
    else $error("clear left elements behind");

  a_err_hold: assert property (@(posedge clk) disable iff (rst)
    (status != ST_OK) |-> ((cnt_next == cnt) && (ctl.op == OP_HOLD)))
    else $error("refused command changes the list");

  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    fire && (ctl.op == OP_INS) |=> (cnt == $past(cnt) + CW'(1)))
    else $error("insert did not grow the count by one");

endmodule

### test/indexed_ordered_list_store_test.sv
`timescale 1ns / 100ps
// Testbench for indexed_ordered_list_store: a directed table, then biased random commands.
// Every result word is checked against the table or a list mirror kept here. Depends on iols_pkg.
module indexed_ordered_list_store_test;
  import iols_pkg::*;

  localparam int CAP          = 16;
  localparam int RANDOM_ITEMS = 650;
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 200000;

  // Kinds with no function; the block must leave the list alone
  localparam logic [3:0] K_SPARE_LO = 4'd12;
  localparam logic [3:0] K_SPARE_HI = 4'd15;

  localparam out_word_t NO_WANT = '0;

  typedef struct packed {
    in_word_t  cmd;
    int        reps;
    bit        typed;
    out_word_t want;
  } drill_row_t;

  localparam int DRILL_ROWS = 24;

  drill_row_t drill_plan [0:DRILL_ROWS-1] = '{
    '{'{K_READ_FIRST, 32'h0, 5'd0}, 1, 1'b1, '{32'h0, 5'd0, ST_EMPTY}},
    '{'{K_POP_FRONT, 32'h0, 5'd0}, 1, 1'b1, '{32'h0, 5'd0, ST_EMPTY}},
    '{'{K_POP_BACK, 32'h0, 5'd0}, 1, 1'b1, '{32'h0, 5'd0, ST_EMPTY}},
    '{'{K_READ_LAST, 32'h0, 5'd0}, 1, 1'b1, '{32'h0, 5'd0, ST_EMPTY}},
    '{'{K_REMOVE_AT, 32'h0, 5'd0}, 1, 1'b1, '{32'h0, 5'd0, ST_RANGE}},
    '{'{K_REPLACE, 32'hFFFF_FFFF, 5'd0}, 1, 1'b1, '{32'h0, 5'd0, ST_RANGE}},
    '{'{K_READ_AT, 32'h0, 5'd31}, 1, 1'b1, '{32'h0, 5'd0, ST_RANGE}},
    '{'{K_INSERT_AT, 32'h1, 5'd1}, 1, 1'b1, '{32'h0, 5'd0, ST_RANGE}},
    '{'{K_PUSH_BACK, 32'hFFFF_FFFF, 5'd0}, 1, 1'b1, '{32'h0, 5'd1, ST_OK}},
    '{'{K_PUSH_FRONT, 32'h0, 5'd0}, 1, 1'b1, '{32'h0, 5'd2, ST_OK}},
    '{'{K_SORTED_INS, 32'h8000_0000, 5'd0}, 1, 1'b1, '{32'h0, 5'd3, ST_OK}},
    // equal value goes after the one already stored
    '{'{K_SORTED_INS, 32'h8000_0000, 5'd0}, 1, 1'b0, NO_WANT},
    // position equal to the count appends
    '{'{K_INSERT_AT, 32'h5, 5'd4}, 1, 1'b0, NO_WANT},
    '{'{K_READ_AT, 32'h0, 5'd0}, 1, 1'b1, '{32'h0, 5'd5, ST_OK}},
    '{'{K_REPLACE, 32'hA5A5_A5A5, 5'd2}, 1, 1'b0, NO_WANT},
    '{'{K_REMOVE_AT, 32'h0, 5'd1}, 1, 1'b0, NO_WANT},
    '{'{K_POP_FRONT, 32'h0, 5'd0}, 1, 1'b0, NO_WANT},
    '{'{K_POP_BACK, 32'h0, 5'd0}, 1, 1'b0, NO_WANT},
    '{'{K_SPARE_LO, 32'hDEAD_BEEF, 5'd0}, 1, 1'b0, NO_WANT},
    '{'{K_PUSH_BACK, 32'h7FFF_FFF8, 5'd0}, 14, 1'b0, NO_WANT},
    // full is checked before the position
    '{'{K_INSERT_AT, 32'h3, 5'd31}, 1, 1'b1, '{32'h0, 5'd16, ST_FULL}},
    '{'{K_SORTED_INS, 32'h3, 5'd0}, 1, 1'b1, '{32'h0, 5'd16, ST_FULL}},
    '{'{K_REMOVE_AT, 32'h0, 5'd16}, 1, 1'b1, '{32'h0, 5'd16, ST_RANGE}},
    '{'{K_CLEAR, 32'h0, 5'd0}, 1, 1'b1, '{32'h0, 5'd0, ST_OK}}
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  logic [31:0] list_mirror [CAP];
  int          mirror_count = 0;
  int          peak_count = 0;
  out_word_t   expected_results [$];

  int mismatch_count = 0;
  int words_sent = 0;
  int results_checked = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int cycle_count = 0;

  bit steady_flow = 1'b0;
  bit hold_request = 1'b0;

  indexed_ordered_list_store #(
    .CAPACITY  (CAP),
    .DATA_WIDTH(32)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("indexed_ordered_list_store_test failed");
      $finish;
    end
  end

  // Apply one command to the mirror and return the result word it should give
  function automatic out_word_t apply_command(in_word_t cmd);
    out_word_t r;
    int        slot;
    bit        grow;
    bit        shrink;
    r = '0;
    r.status = ST_OK;
    slot = 0;
    grow = 1'b0;
    shrink = 1'b0;
    case (cmd.kind)
      K_PUSH_FRONT, K_PUSH_BACK, K_INSERT_AT, K_SORTED_INS: begin
        if (mirror_count == CAP) begin
          r.status = ST_FULL;
        end else if (cmd.kind == K_INSERT_AT && cmd.position > mirror_count) begin
          r.status = ST_RANGE;
        end else begin
          grow = 1'b1;
          if (cmd.kind == K_PUSH_BACK) begin
            slot = mirror_count;
          end else if (cmd.kind == K_INSERT_AT) begin
            slot = cmd.position;
          end else if (cmd.kind == K_SORTED_INS) begin
            while (slot < mirror_count && list_mirror[slot] <= cmd.value) slot++;
          end
        end
      end
      K_POP_FRONT, K_POP_BACK: begin
        if (mirror_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shrink = 1'b1;
          slot = (cmd.kind == K_POP_FRONT) ? 0 : mirror_count - 1;
        end
      end
      K_REMOVE_AT, K_REPLACE, K_READ_AT: begin
        if (cmd.position >= mirror_count) begin
          r.status = ST_RANGE;
        end else if (cmd.kind == K_REMOVE_AT) begin
          shrink = 1'b1;
          slot = cmd.position;
        end else if (cmd.kind == K_REPLACE) begin
          list_mirror[cmd.position] = cmd.value;
        end else begin
          r.read_value = list_mirror[cmd.position];
        end
      end
      K_READ_FIRST, K_READ_LAST: begin
        if (mirror_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.read_value = list_mirror[(cmd.kind == K_READ_FIRST) ? 0 : mirror_count - 1];
        end
      end
      K_CLEAR: begin
        mirror_count = 0;
      end
      default: begin
      end
    endcase
    // Shift the tail up or down by one slot
    if (grow) begin
      for (int i = mirror_count; i > slot; i--) list_mirror[i] = list_mirror[i-1];
      list_mirror[slot] = cmd.value;
      mirror_count++;
    end
    if (shrink) begin
      for (int i = slot; i < mirror_count - 1; i++) list_mirror[i] = list_mirror[i+1];
      mirror_count--;
    end
    r.entry_total = 5'(mirror_count);
    return r;
  endfunction

  // Fill-leaning mixes favour inserts so the list reaches full; drain-leaning ones empty it
  function automatic in_word_t pick_command(bit filling);
    in_word_t w;
    int       roll;
    roll = $urandom_range(0, 99);
    if (roll < (filling ? 55 : 20)) begin
      w.kind = K_PUSH_FRONT + 4'($urandom_range(0, 3));
    end else if (roll < (filling ? 65 : 55)) begin
      w.kind = K_POP_FRONT + 4'($urandom_range(0, 2));
    end else if (roll < 95) begin
      w.kind = K_REPLACE + 4'($urandom_range(0, 3));
    end else if (roll < (filling ? 96 : 98)) begin
      w.kind = K_CLEAR;
    end else begin
      w.kind = 4'($urandom_range(K_SPARE_LO, K_SPARE_HI));
    end
    // Small values give plenty of equal keys for sorted insert
    roll = $urandom_range(0, 9);
    if (roll < 3) begin
      w.value = $urandom_range(0, 7);
    end else if (roll == 3) begin
      w.value = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
    end else begin
      w.value = $urandom;
    end
    if ($urandom_range(0, 4) == 0) begin
      w.position = 5'($urandom_range(0, 31));
    end else begin
      w.position = 5'($urandom_range(0, mirror_count));
    end
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(in_word_t w, bit typed, out_word_t want);
    int        gap;
    out_word_t predicted;
    gap = (steady_flow || hold_request) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    predicted = apply_command(w);
    expected_results.push_back(typed ? want : predicted);
    words_sent++;
    if (mirror_count > peak_count) peak_count = mirror_count;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: %h", out_data);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, out_data.read_value);
          mismatch_count++;
        end
        if (out_data.entry_total !== want.entry_total) begin
          $error("entry_total: expected %0d, got %0d", want.entry_total, out_data.entry_total);
          mismatch_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatch_count++;
        end
        status_seen[want.status]++;
        results_checked++;
      end
    end
  end

  // Result side: random stall per word, plus one long hold-off on request
  initial begin
    int wait_cycles;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      wait_cycles = steady_flow ? 0 : $urandom_range(0, 7);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    in_word_t w;
    bit       filling;
    filling = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int row = 0; row < DRILL_ROWS; row++) begin
      for (int rep = 0; rep < drill_plan[row].reps; rep++) begin
        w = drill_plan[row].cmd;
        w.value = w.value + 32'(rep);
        send_word(w, drill_plan[row].typed, drill_plan[row].want);
      end
    end
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        filling = $urandom_range(0, 1);
        steady_flow = ($urandom_range(0, 3) == 0);
      end
      // Hold the result side so the block backs up onto its input
      if (n == 300) hold_request = 1'b1;
      if (n == 450) drain_results();
      send_word(pick_command(filling), 1'b0, NO_WANT);
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);

    $display("Summary: %0d command words sent, %0d result words checked", words_sent,
             results_checked);
    $display("Summary: ok %0d, range %0d, empty %0d, full %0d; peak fill %0d of %0d",
             status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_EMPTY],
             status_seen[ST_FULL], peak_count, CAP);
    if (mismatch_count == 0) begin
      $display("indexed_ordered_list_store_test passed");
    end else begin
      $display("indexed_ordered_list_store_test failed");
    end
    $finish;
  end

endmodule
